>>> hw/rtl/bidi_weak_type_resolver_defines.svh
// Assertion macros shared by the resolver RTL.
`ifndef BIDI_WEAK_TYPE_RESOLVER_DEFINES_SVH
`define BIDI_WEAK_TYPE_RESOLVER_DEFINES_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge out of reset.
`define BWTR_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("bwtr: assertion failed");
// Condition must never be true out of reset.
`define BWTR_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("bwtr: forbidden condition seen");
`else
`define BWTR_ASSERT(lbl, clk, rstn, prop)
`define BWTR_NEVER(lbl, clk, rstn, cond)
`endif

`endif

>>> hw/rtl/bwtr_pkg.sv
// Types, codes and weak-type rule tables for the bidi weak-type resolver.
package bwtr_pkg;

  localparam longint unsigned RUN_COUNT_MAX_DEF = 64'd65535;
  localparam int LEVEL_BITS_DEF = 6;
  localparam int CFG_W = 6;
  localparam int CLASS_W = 4;
  localparam int RUN_CLASS_W = 3;
  localparam int RUN_LEN_W = 16;

  // Result queue
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Class codes
  localparam logic [CLASS_W-1:0] CLS_ON = 4'd0;
  localparam logic [CLASS_W-1:0] CLS_L  = 4'd1;
  localparam logic [CLASS_W-1:0] CLS_R  = 4'd2;
  localparam logic [CLASS_W-1:0] CLS_BN = 4'd10;

  // Action word: bit 8 extends the run, bits 7:4 run class, bits 3:0 item class
  localparam int ACT_INC_BIT = 8;
  localparam logic [3:0] ACT_KEEP = 4'hF;

  localparam logic [8:0] P_KK = 9'h0FF;
  localparam logic [8:0] P_KI = 9'h1FF;
  localparam logic [8:0] P_KN = 9'h0F0;
  localparam logic [8:0] P_KE = 9'h0F4;
  localparam logic [8:0] P_KA = 9'h0F3;
  localparam logic [8:0] P_KR = 9'h0F2;
  localparam logic [8:0] P_KL = 9'h0F1;
  localparam logic [8:0] P_NK = 9'h00F;
  localparam logic [8:0] P_AK = 9'h03F;
  localparam logic [8:0] P_EE = 9'h044;
  localparam logic [8:0] P_NI = 9'h10F;
  localparam logic [8:0] P_NN = 9'h000;
  localparam logic [8:0] P_NR = 9'h002;
  localparam logic [8:0] P_NE = 9'h004;
  localparam logic [8:0] P_AA = 9'h033;
  localparam logic [8:0] P_NL = 9'h001;
  localparam logic [8:0] P_LL = 9'h011;

  typedef enum logic [4:0] {
    WA, WR, WL, WAO, WRO, WLO, WRT, WLT, WCN, WRA, WRE, WLA, WLE,
    WAC, WRC, WRS, WLC, WLS, WRET, WLET
  } weak_t;

  typedef struct packed {
    logic push;  // write the item result
    logic two;   // also write the end-of-paragraph flush
  } push_t;

  localparam weak_t NEXT_TAB [20][10] = '{
    '{WAO, WL, WR, WCN, WCN, WA, WA,   WAO, WAO, WAO },
    '{WRO, WL, WR, WRA, WRE, WA, WR,   WRO, WRO, WRT },
    '{WLO, WL, WR, WLA, WLE, WA, WL,   WLO, WLO, WLT },
    '{WAO, WL, WR, WCN, WCN, WA, WAO,  WAO, WAO, WAO },
    '{WRO, WL, WR, WRA, WRE, WA, WRO,  WRO, WRO, WRT },
    '{WLO, WL, WR, WLA, WLE, WA, WLO,  WLO, WLO, WLT },
    '{WRO, WL, WR, WRA, WRE, WA, WRT,  WRO, WRO, WRT },
    '{WLO, WL, WR, WLA, WLE, WA, WLT,  WLO, WLO, WLT },
    '{WAO, WL, WR, WCN, WCN, WA, WCN,  WAC, WAO, WAO },
    '{WRO, WL, WR, WRA, WRE, WA, WRA,  WRC, WRO, WRT },
    '{WRO, WL, WR, WRA, WRE, WA, WRE,  WRS, WRS, WRET},
    '{WLO, WL, WR, WLA, WLE, WA, WLA,  WLC, WLO, WLT },
    '{WLO, WL, WR, WLA, WLE, WA, WLE,  WLS, WLS, WLET},
    '{WAO, WL, WR, WCN, WCN, WA, WAO,  WAO, WAO, WAO },
    '{WRO, WL, WR, WRA, WRE, WA, WRO,  WRO, WRO, WRT },
    '{WRO, WL, WR, WRA, WRE, WA, WRO,  WRO, WRO, WRT },
    '{WLO, WL, WR, WLA, WLE, WA, WLO,  WLO, WLO, WLT },
    '{WLO, WL, WR, WLA, WLE, WA, WLO,  WLO, WLO, WLT },
    '{WRO, WL, WR, WRA, WRE, WA, WRET, WRO, WRO, WRET},
    '{WLO, WL, WR, WLA, WLE, WA, WLET, WLO, WLO, WLET}
  };

  localparam logic [8:0] ACT_TAB [20][10] = '{
    '{P_KK, P_KK, P_KK, P_KK, P_KA, P_KR, P_KR, P_KN, P_KN, P_KN},
    '{P_KK, P_KK, P_KK, P_KK, P_KE, P_KR, P_KR, P_KN, P_KN, P_KI},
    '{P_KK, P_KK, P_KK, P_KK, P_KL, P_KR, P_KL, P_KN, P_KN, P_KI},
    '{P_KK, P_KK, P_KK, P_KK, P_KA, P_KR, P_KN, P_KN, P_KN, P_KN},
    '{P_KK, P_KK, P_KK, P_KK, P_KE, P_KR, P_KN, P_KN, P_KN, P_KI},
    '{P_KK, P_KK, P_KK, P_KK, P_KL, P_KR, P_KN, P_KN, P_KN, P_KI},
    '{P_NK, P_NK, P_NK, P_NK, P_EE, P_NR, P_KI, P_NN, P_NN, P_KI},
    '{P_NK, P_NK, P_NK, P_NK, P_LL, P_NR, P_KI, P_NN, P_NN, P_KI},
    '{P_KK, P_KK, P_KK, P_KK, P_KA, P_KR, P_KA, P_KI, P_KN, P_KN},
    '{P_KK, P_KK, P_KK, P_KK, P_KE, P_KR, P_KA, P_KI, P_KN, P_KI},
    '{P_KK, P_KK, P_KK, P_KK, P_KE, P_KR, P_KE, P_KI, P_KI, P_KE},
    '{P_KK, P_KK, P_KK, P_KK, P_KL, P_KR, P_KA, P_KI, P_KN, P_KI},
    '{P_KK, P_KK, P_KK, P_KK, P_KL, P_KR, P_KL, P_KI, P_KI, P_KL},
    '{P_NK, P_NK, P_NK, P_AK, P_AA, P_NR, P_NN, P_NN, P_NN, P_NN},
    '{P_NK, P_NK, P_NK, P_AK, P_NE, P_NR, P_NN, P_NN, P_NN, P_NI},
    '{P_NK, P_NK, P_NK, P_NK, P_EE, P_NR, P_NN, P_NN, P_NN, P_NI},
    '{P_NK, P_NK, P_NK, P_AK, P_NL, P_NR, P_NN, P_NN, P_NN, P_NI},
    '{P_NK, P_NK, P_NK, P_NK, P_LL, P_NR, P_NN, P_NN, P_NN, P_NI},
    '{P_KK, P_KK, P_KK, P_KK, P_KE, P_KR, P_KE, P_KN, P_KN, P_KE},
    '{P_KK, P_KK, P_KK, P_KK, P_KL, P_KR, P_KL, P_KN, P_KN, P_KL}
  };

  // Direction of a level: odd is right-to-left
  function automatic logic [CLASS_W-1:0] dir_of(input logic odd);
    return odd ? CLS_R : CLS_L;
  endfunction

endpackage

>>> hw/rtl/bwtr_if.sv
// Valid/ready channel interfaces for resolver input and result transactions.
interface bwtr_in_if #(
  parameter int LEVEL_BITS = bwtr_pkg::LEVEL_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [3:0]            class_in;
  logic [LEVEL_BITS-1:0] level_in;
  logic [3:0]            next_class;
  logic [LEVEL_BITS-1:0] next_level;
  logic                  is_last;

  modport source (output valid, class_in, level_in, next_class, next_level, is_last,
                  input ready);
  modport sink (input valid, class_in, level_in, next_class, next_level, is_last,
                output ready);
endinterface

interface bwtr_out_if #(
  parameter int LEVEL_BITS = bwtr_pkg::LEVEL_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  kind;
  logic [3:0]            class_out;
  logic [LEVEL_BITS-1:0] level_out;
  logic                  run_valid;
  logic [2:0]            run_class;
  logic [15:0]           run_length;
  logic                  last_result;

  modport source (output valid, kind, class_out, level_out, run_valid, run_class,
                  run_length, last_result, input ready);
  modport sink (input valid, kind, class_out, level_out, run_valid, run_class,
                run_length, last_result, output ready);
endinterface

>>> hw/rtl/bwtr_core.sv
// Weak-type state machine: rule tables, boundary-neutral fix-ups, run counter.
`include "bidi_weak_type_resolver_defines.svh"

module bwtr_core #(
  parameter longint unsigned RUN_COUNT_MAX = 64'd65535,
  parameter int              LEVEL_BITS    = 6,
  parameter int              RES_W         = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [bwtr_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          acc,
  input  logic [3:0]                    class_in,
  input  logic [LEVEL_BITS-1:0]         level_in,
  input  logic [3:0]                    next_class,
  input  logic [LEVEL_BITS-1:0]         next_level,
  input  logic                          is_last,
  output bwtr_pkg::push_t               push,
  output logic [RES_W-1:0]              res0,
  output logic [RES_W-1:0]              res1
);
  import bwtr_pkg::*;

  localparam int CNT_W = $clog2(RUN_COUNT_MAX + 64'd1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(RUN_COUNT_MAX);

  logic [CFG_W-1:0]      base_r;
  weak_t                 ws_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [LEVEL_BITS-1:0] cur_r;

  weak_t                 ws_safe, ws_nxt;
  logic [CNT_W-1:0]      cnt_nxt;
  logic [LEVEL_BITS-1:0] cur_nxt, base_lvl, lvl_out, hi_lvl;
  logic [3:0]            cls, ncls, cls_t, cls_out, fc;
  logic                  use_tab;
  logic [8:0]            act, act_f;
  logic                  rv, rv_f;
  logic [2:0]            rcls, rcls_f;
  logic [15:0]           rlen, rlen_f;

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
    return (c < CNT_MAX) ? c + CNT_W'(1) : c;
  endfunction

  function automatic logic [15:0] sat16(input logic [CNT_W-1:0] c);
    logic [32:0] w;
    w = 33'(c);
    return (w > 33'h0FFFF) ? 16'hFFFF : w[15:0];
  endfunction

  assign base_lvl = LEVEL_BITS'(base_r);
  assign ws_safe  = (ws_r > WLET) ? WL : ws_r;
  assign cls      = (class_in > CLS_BN) ? CLS_ON : class_in;
  assign ncls     = (next_class > CLS_BN) ? CLS_ON : next_class;
  assign hi_lvl   = (cur_r > next_level) ? cur_r : next_level;

  // Item step
  always_comb begin
    cls_t   = cls;
    lvl_out = level_in;
    cur_nxt = cur_r;
    use_tab = 1'b1;
    cnt_nxt = cnt_r;
    if (cls == CLS_BN) begin
      lvl_out = cur_r;
      if (is_last && (cur_r != base_lvl)) begin
        cls_t = dir_of(cur_r[0]);
      end else if (!is_last && (cur_r != next_level) && (ncls != CLS_BN)) begin
        lvl_out = hi_lvl;
        cls_t   = dir_of(hi_lvl[0]);
        cur_nxt = next_level;
      end else begin
        use_tab = 1'b0;
        if (cnt_r != '0) begin
          cnt_nxt = bump(cnt_r);
        end
      end
    end

    act     = ACT_TAB[ws_safe][cls_t];
    ws_nxt  = ws_safe;
    cls_out = cls_t;
    rv      = 1'b0;
    rcls    = '0;
    rlen    = '0;
    if (use_tab) begin
      if (act[7:4] != ACT_KEEP) begin
        rv      = 1'b1;
        rcls    = act[6:4];
        rlen    = sat16(cnt_r);
        cnt_nxt = '0;
      end
      if (act[ACT_INC_BIT]) begin
        cnt_nxt = bump(cnt_nxt);
      end
      ws_nxt = NEXT_TAB[ws_safe][cls_t];
      if (act[3:0] != ACT_KEEP) begin
        cls_out = act[3:0];
      end
    end
  end

  // End-of-paragraph flush uses the direction of the level left by the item
  always_comb begin
    fc     = dir_of(cur_nxt[0]);
    act_f  = ACT_TAB[(ws_nxt > WLET) ? WL : ws_nxt][fc];
    rv_f   = 1'b0;
    rcls_f = '0;
    rlen_f = '0;
    if (act_f[7:4] != ACT_KEEP) begin
      rv_f   = 1'b1;
      rcls_f = act_f[6:4];
      rlen_f = sat16(cnt_nxt);
    end
  end

  assign push.push = acc;
  assign push.two  = acc & is_last;
  assign res0 = {1'b0, cls_out, lvl_out, rv, rcls, rlen, ~is_last};
  assign res1 = {1'b1, fc, cur_nxt, rv_f, rcls_f, rlen_f, 1'b1};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      ws_r   <= WL;
      cnt_r  <= '0;
      cur_r  <= '0;
    end else if (cfg_we) begin
      base_r <= cfg_data;
      ws_r   <= cfg_data[0] ? WR : WL;
      cnt_r  <= '0;
      cur_r  <= LEVEL_BITS'(cfg_data);
    end else if (acc) begin
      if (is_last) begin
        ws_r  <= base_r[0] ? WR : WL;
        cnt_r <= '0;
        cur_r <= base_lvl;
      end else begin
        ws_r  <= ws_nxt;
        cnt_r <= cnt_nxt;
        cur_r <= cur_nxt;
      end
    end
  end

  `BWTR_NEVER(a_cnt_sat, clk, rst_n, cnt_r > CNT_MAX)
  `BWTR_ASSERT(a_para_restart, clk, rst_n, (acc && is_last && !cfg_we) |=> ((cnt_r == '0) && (cur_r == LEVEL_BITS'(base_r))))

endmodule

>>> hw/rtl/bwtr_outq.sv
// Result queue: takes one or two results per transaction, drains one per cycle while q_ready is high.
`include "bidi_weak_type_resolver_defines.svh"

module bwtr_outq #(
  parameter int RES_W = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  bwtr_pkg::push_t   push,
  input  logic [RES_W-1:0]  res0,
  input  logic [RES_W-1:0]  res1,
  output logic              in_ready,
  output logic              q_valid,
  input  logic              q_ready,
  output logic [RES_W-1:0]  q_data
);
  import bwtr_pkg::*;

  logic [RES_W-1:0]   mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] count_r;
  logic               pop;

  assign pop      = q_valid & q_ready;
  assign q_valid  = (count_r != '0);
  assign q_data   = mem[rd_ptr_r];
  // room for a full last-item pair regardless of the drain side
  assign in_ready = (count_r <= Q_CNT_W'(Q_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.push) begin
      mem[wr_ptr_r] <= res0;
    end
    if (push.two) begin
      mem[wr_ptr_r + Q_PTR_W'(1)] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + Q_PTR_W'(push.push) + Q_PTR_W'(push.two);
      rd_ptr_r <= rd_ptr_r + Q_PTR_W'(pop);
      count_r  <= count_r + Q_CNT_W'(push.push) + Q_CNT_W'(push.two) - Q_CNT_W'(pop);
    end
  end

  `BWTR_NEVER(a_no_overflow, clk, rst_n, count_r > Q_CNT_W'(Q_DEPTH))
  `BWTR_ASSERT(a_drain_step, clk, rst_n, (pop && !push.push) |=> (count_r == $past(count_r) - Q_CNT_W'(1)))

endmodule

>>> hw/rtl/bidi_weak_type_resolver.sv
// Top level of the streaming bidi weak-type resolver.
//
// Input channel in_if: one character per transaction with its class, level,
// a look-ahead of the next character's class and level, and is_last.
// Result channel out_if: one result per character (kind 0); the last
// character of a paragraph also yields an end flush (kind 1) right after it.
// last_result marks the final result of each input transaction.
// Configuration: cfg_we/cfg_data write base_level and restart the paragraph.
// Each result is registered in the result queue when its input is accepted.
// Throughput: one character per cycle while the queue has room; the state machine
// step and run counter update fit in the accept cycle, and the four-entry result
// queue sustains one result out per cycle while out_if.ready is high.
// Stall: in_if.ready drops whenever the queue lacks room for two results,
// so results are held, never dropped, while out_if.ready is low.
// Reset: synchronous rst_n clears the queue, sets base_level to 0 and the
// weak state to left-letter with an empty run.
module bidi_weak_type_resolver #(
  parameter longint unsigned RUN_COUNT_MAX = bwtr_pkg::RUN_COUNT_MAX_DEF,
  parameter int              LEVEL_BITS    = bwtr_pkg::LEVEL_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [bwtr_pkg::CFG_W-1:0] cfg_data,
  bwtr_in_if.sink                    in_if,
  bwtr_out_if.source                 out_if
);
  import bwtr_pkg::*;

  // kind, class, level, run valid, run class, run length, last flag
  localparam int RES_W = 1 + CLASS_W + LEVEL_BITS + 1 + RUN_CLASS_W + RUN_LEN_W + 1;

  logic             acc;
  logic             q_in_ready;
  push_t            push;
  logic [RES_W-1:0] res0, res1, q_data;

  // accept a transaction whenever the queue can take a full pair
  assign in_if.ready = q_in_ready;
  assign acc         = in_if.valid & q_in_ready;

  bwtr_core #(
    .RUN_COUNT_MAX (RUN_COUNT_MAX),
    .LEVEL_BITS    (LEVEL_BITS),
    .RES_W         (RES_W)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .acc        (acc),
    .class_in   (in_if.class_in),
    .level_in   (in_if.level_in),
    .next_class (in_if.next_class),
    .next_level (in_if.next_level),
    .is_last    (in_if.is_last),
    .push       (push),
    .res0       (res0),
    .res1       (res1)
  );

  // hold results until the receiver takes them
  bwtr_outq #(
    .RES_W (RES_W)
  ) u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .res0     (res0),
    .res1     (res1),
    .in_ready (q_in_ready),
    .q_valid  (out_if.valid),
    .q_ready  (out_if.ready),
    .q_data   (q_data)
  );

  // unpack the queue head onto the result channel
  assign {out_if.kind, out_if.class_out, out_if.level_out, out_if.run_valid,
          out_if.run_class, out_if.run_length, out_if.last_result} = q_data;

endmodule

>>> dv/tb.sv
// Self-checking testbench for the bidi weak-type resolver: predictor, scoreboard and drivers.
package bwtr_tb_pkg;
  import bwtr_pkg::*;

  typedef enum logic [3:0] {
    BC_ON, BC_L, BC_R, BC_AN, BC_EN, BC_AL, BC_NSM, BC_CS, BC_ES, BC_ET, BC_BN
  } bidi_class_t;

  // Highest code the 4-bit class field can carry; anything above BC_BN reads as ON
  localparam logic [3:0] BAD_CLASS = 4'hF;

  localparam logic KIND_ITEM  = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // Action word: bit 8 grows the pending run, [7:4] closes the run with that
  // class, [3:0] rewrites the current class; a nibble of all ones leaves it alone
  localparam logic [3:0] NIBBLE_KEEP = 4'hF;
  localparam logic [8:0] AW_KK = 9'h0FF;
  localparam logic [8:0] AW_KI = 9'h1FF;
  localparam logic [8:0] AW_KN = 9'h0F0;
  localparam logic [8:0] AW_KE = 9'h0F4;
  localparam logic [8:0] AW_KA = 9'h0F3;
  localparam logic [8:0] AW_KR = 9'h0F2;
  localparam logic [8:0] AW_KL = 9'h0F1;
  localparam logic [8:0] AW_NK = 9'h00F;
  localparam logic [8:0] AW_AK = 9'h03F;
  localparam logic [8:0] AW_EE = 9'h044;
  localparam logic [8:0] AW_NI = 9'h10F;
  localparam logic [8:0] AW_NN = 9'h000;
  localparam logic [8:0] AW_NR = 9'h002;
  localparam logic [8:0] AW_NE = 9'h004;
  localparam logic [8:0] AW_AA = 9'h033;
  localparam logic [8:0] AW_NL = 9'h001;
  localparam logic [8:0] AW_LL = 9'h011;

  localparam weak_t WEAK_NEXT [20][10] = '{
    '{WAO, WL, WR, WCN, WCN, WA, WA,   WAO, WAO, WAO },
    '{WRO, WL, WR, WRA, WRE, WA, WR,   WRO, WRO, WRT },
    '{WLO, WL, WR, WLA, WLE, WA, WL,   WLO, WLO, WLT },
    '{WAO, WL, WR, WCN, WCN, WA, WAO,  WAO, WAO, WAO },
    '{WRO, WL, WR, WRA, WRE, WA, WRO,  WRO, WRO, WRT },
    '{WLO, WL, WR, WLA, WLE, WA, WLO,  WLO, WLO, WLT },
    '{WRO, WL, WR, WRA, WRE, WA, WRT,  WRO, WRO, WRT },
    '{WLO, WL, WR, WLA, WLE, WA, WLT,  WLO, WLO, WLT },
    '{WAO, WL, WR, WCN, WCN, WA, WCN,  WAC, WAO, WAO },
    '{WRO, WL, WR, WRA, WRE, WA, WRA,  WRC, WRO, WRT },
    '{WRO, WL, WR, WRA, WRE, WA, WRE,  WRS, WRS, WRET},
    '{WLO, WL, WR, WLA, WLE, WA, WLA,  WLC, WLO, WLT },
    '{WLO, WL, WR, WLA, WLE, WA, WLE,  WLS, WLS, WLET},
    '{WAO, WL, WR, WCN, WCN, WA, WAO,  WAO, WAO, WAO },
    '{WRO, WL, WR, WRA, WRE, WA, WRO,  WRO, WRO, WRT },
    '{WRO, WL, WR, WRA, WRE, WA, WRO,  WRO, WRO, WRT },
    '{WLO, WL, WR, WLA, WLE, WA, WLO,  WLO, WLO, WLT },
    '{WLO, WL, WR, WLA, WLE, WA, WLO,  WLO, WLO, WLT },
    '{WRO, WL, WR, WRA, WRE, WA, WRET, WRO, WRO, WRET},
    '{WLO, WL, WR, WLA, WLE, WA, WLET, WLO, WLO, WLET}
  };

  localparam logic [8:0] WEAK_ACTION [20][10] = '{
    '{AW_KK, AW_KK, AW_KK, AW_KK, AW_KA, AW_KR, AW_KR, AW_KN, AW_KN, AW_KN},
    '{AW_KK, AW_KK, AW_KK, AW_KK, AW_KE, AW_KR, AW_KR, AW_KN, AW_KN, AW_KI},
    '{AW_KK, AW_KK, AW_KK, AW_KK, AW_KL, AW_KR, AW_KL, AW_KN, AW_KN, AW_KI},
    '{AW_KK, AW_KK, AW_KK, AW_KK, AW_KA, AW_KR, AW_KN, AW_KN, AW_KN, AW_KN},
    '{AW_KK, AW_KK, AW_KK, AW_KK, AW_KE, AW_KR, AW_KN, AW_KN, AW_KN, AW_KI},
    '{AW_KK, AW_KK, AW_KK, AW_KK, AW_KL, AW_KR, AW_KN, AW_KN, AW_KN, AW_KI},
    '{AW_NK, AW_NK, AW_NK, AW_NK, AW_EE, AW_NR, AW_KI, AW_NN, AW_NN, AW_KI},
    '{AW_NK, AW_NK, AW_NK, AW_NK, AW_LL, AW_NR, AW_KI, AW_NN, AW_NN, AW_KI},
    '{AW_KK, AW_KK, AW_KK, AW_KK, AW_KA, AW_KR, AW_KA, AW_KI, AW_KN, AW_KN},
    '{AW_KK, AW_KK, AW_KK, AW_KK, AW_KE, AW_KR, AW_KA, AW_KI, AW_KN, AW_KI},
    '{AW_KK, AW_KK, AW_KK, AW_KK, AW_KE, AW_KR, AW_KE, AW_KI, AW_KI, AW_KE},
    '{AW_KK, AW_KK, AW_KK, AW_KK, AW_KL, AW_KR, AW_KA, AW_KI, AW_KN, AW_KI},
    '{AW_KK, AW_KK, AW_KK, AW_KK, AW_KL, AW_KR, AW_KL, AW_KI, AW_KI, AW_KL},
    '{AW_NK, AW_NK, AW_NK, AW_AK, AW_AA, AW_NR, AW_NN, AW_NN, AW_NN, AW_NN},
    '{AW_NK, AW_NK, AW_NK, AW_AK, AW_NE, AW_NR, AW_NN, AW_NN, AW_NN, AW_NI},
    '{AW_NK, AW_NK, AW_NK, AW_NK, AW_EE, AW_NR, AW_NN, AW_NN, AW_NN, AW_NI},
    '{AW_NK, AW_NK, AW_NK, AW_AK, AW_NL, AW_NR, AW_NN, AW_NN, AW_NN, AW_NI},
    '{AW_NK, AW_NK, AW_NK, AW_NK, AW_LL, AW_NR, AW_NN, AW_NN, AW_NN, AW_NI},
    '{AW_KK, AW_KK, AW_KK, AW_KK, AW_KE, AW_KR, AW_KE, AW_KN, AW_KN, AW_KE},
    '{AW_KK, AW_KK, AW_KK, AW_KK, AW_KL, AW_KR, AW_KL, AW_KN, AW_KN, AW_KL}
  };

  // Class mix for well-formed text
  localparam bidi_class_t CLASS_POOL [20] = '{
    BC_L, BC_L, BC_L, BC_R, BC_R, BC_AL, BC_EN, BC_EN, BC_EN, BC_AN,
    BC_AN, BC_ES, BC_CS, BC_CS, BC_ET, BC_ET, BC_NSM, BC_ON, BC_BN, BC_BN
  };

  typedef struct packed {
    logic [3:0] cls;
    logic [5:0] lvl;
    logic [3:0] ncls;
    logic [5:0] nlvl;
    logic       last;
  } char_t;

  typedef struct packed {
    logic        kind;
    logic [3:0]  cls;
    logic [5:0]  lvl;
    logic        run_valid;
    logic [2:0]  run_cls;
    logic [15:0] run_len;
    logic        last;
  } result_t;

  // Mostly no gap, sometimes a short one, rarely a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [3:0] level_dir(input logic [5:0] lvl);
    return lvl[0] ? BC_R : BC_L;
  endfunction

  class weak_type_scoreboard;
    logic [5:0]  base_lvl;
    logic [5:0]  cur_lvl;
    weak_t       wstate;
    int unsigned run_len;
    result_t     pending[$];
    int unsigned mismatches;
    int unsigned results_seen;

    function new();
      mismatches = 0;
      results_seen = 0;
      set_base(6'd0);
    endfunction

    function void restart();
      wstate = base_lvl[0] ? WR : WL;
      run_len = 0;
      cur_lvl = base_lvl;
    endfunction

    function void set_base(input logic [5:0] b);
      base_lvl = b;
      restart();
    endfunction

    function void extend_run();
      if (run_len < RUN_COUNT_MAX_DEF) run_len++;
    endfunction

    // Resolve one accepted character and queue the results it should cause
    function void note_char(input char_t c);
      logic [3:0] cls;
      logic [3:0] ncls;
      logic [3:0] end_cls;
      logic [5:0] lvl_res;
      logic [5:0] hi;
      logic [8:0] act;
      result_t    r;
      bit         stepped;
      cls = (c.cls > BC_BN) ? BC_ON : c.cls;
      ncls = (c.ncls > BC_BN) ? BC_ON : c.ncls;
      lvl_res = c.lvl;
      stepped = 1'b1;
      r = '0;
      if (cls == BC_BN) begin
        lvl_res = cur_lvl;
        if (c.last && cur_lvl != base_lvl) begin
          cls = level_dir(cur_lvl);
        end else if (!c.last && cur_lvl != c.nlvl && ncls != BC_BN) begin
          hi = (cur_lvl > c.nlvl) ? cur_lvl : c.nlvl;
          lvl_res = hi;
          cls = level_dir(hi);
          cur_lvl = c.nlvl;
        end else begin
          if (run_len != 0) extend_run();
          stepped = 1'b0;
        end
      end
      if (stepped) begin
        act = WEAK_ACTION[wstate][cls];
        if (act[7:4] != NIBBLE_KEEP) begin
          r.run_valid = 1'b1;
          r.run_cls = act[6:4];
          r.run_len = 16'(run_len);
          run_len = 0;
        end
        if (act[8]) extend_run();
        wstate = WEAK_NEXT[wstate][cls];
        if (act[3:0] != NIBBLE_KEEP) cls = act[3:0];
      end
      r.kind = KIND_ITEM;
      r.cls = cls;
      r.lvl = lvl_res;
      r.last = !c.last;
      pending.push_back(r);
      if (c.last) begin
        r = '0;
        end_cls = level_dir(cur_lvl);
        act = WEAK_ACTION[wstate][end_cls];
        if (act[7:4] != NIBBLE_KEEP) begin
          r.run_valid = 1'b1;
          r.run_cls = act[6:4];
          r.run_len = 16'(run_len);
        end
        r.kind = KIND_FLUSH;
        r.cls = end_cls;
        r.lvl = cur_lvl;
        r.last = 1'b1;
        pending.push_back(r);
        restart();
      end
    endfunction

    task report(input string msg);
      mismatches++;
      if (mismatches <= 50) $display("MISMATCH result %0d: %s", results_seen, msg);
    endtask

    task check_result(input result_t got);
      result_t want;
      results_seen++;
      if (pending.size() == 0) begin
        report("result arrived with nothing outstanding");
        return;
      end
      want = pending.pop_front();
      if (got.kind !== want.kind)
        report($sformatf("kind %0h, want %0h", got.kind, want.kind));
      if (got.cls !== want.cls)
        report($sformatf("class_out %0d, want %0d", got.cls, want.cls));
      if (got.lvl !== want.lvl)
        report($sformatf("level_out %0d, want %0d", got.lvl, want.lvl));
      if (got.run_valid !== want.run_valid)
        report($sformatf("run_valid %0h, want %0h", got.run_valid, want.run_valid));
      if (got.run_cls !== want.run_cls)
        report($sformatf("run_class %0d, want %0d", got.run_cls, want.run_cls));
      if (got.run_len !== want.run_len)
        report($sformatf("run_length %0d, want %0d", got.run_len, want.run_len));
      if (got.last !== want.last)
        report($sformatf("last_result %0h, want %0h", got.last, want.last));
    endtask
  endclass
endpackage

module tb;
  import bwtr_pkg::*;
  import bwtr_tb_pkg::*;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_data;

  bwtr_in_if  in_if ();
  bwtr_out_if out_if ();

  bidi_weak_type_resolver uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .in_if   (in_if),
    .out_if  (out_if)
  );

  weak_type_scoreboard sb = new();

  // When set, both sides run flat out: no input gaps, no result stalls
  bit         steady = 1'b0;
  logic [5:0] cur_base = 6'd0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop: generous against the slowest legal run, which is well under
  // a fifth of this even with every long gap and stall landing
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

  // Result side: check every accepted transaction, then pick next cycle's ready
  initial begin : result_sink
    int unsigned stall;
    result_t     got;
    stall = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        got.kind      = out_if.kind;
        got.cls       = out_if.class_out;
        got.lvl       = out_if.level_out;
        got.run_valid = out_if.run_valid;
        got.run_cls   = out_if.run_class;
        got.run_len   = out_if.run_length;
        got.last      = out_if.last_result;
        sb.check_result(got);
      end
      // Hold ready low through a stall, otherwise raise it and draw the next stall
      if (stall != 0 && !steady) begin
        out_if.ready <= 1'b0;
        stall--;
      end else begin
        out_if.ready <= 1'b1;
        stall = steady ? 0 : pick_gap();
      end
    end
  end

  // Offer one character and hold it until the block takes it. Valid stays high
  // from the previous transaction when there is no gap, so between characters
  // it is lowered here only for a gap, in the step right after the previous acceptance.
  task automatic send_char(input char_t c);
    int unsigned gap;
    gap = steady ? 0 : pick_gap();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.class_in   <= c.cls;
    in_if.level_in   <= c.lvl;
    in_if.next_class <= c.ncls;
    in_if.next_level <= c.nlvl;
    in_if.is_last    <= c.last;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.note_char(c);
  endtask

  // Drop valid, drain every outstanding result, let the pipeline settle,
  // then write base_level; the predictor restarts its paragraph with it
  task automatic write_base(input logic [5:0] b);
    in_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= b;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_base(b);
    cur_base = b;
  endtask

  // Build one paragraph of drifting levels and mostly real classes, then send
  // it with a look-ahead that matches the next character, except for a little
  // noise: undefined class codes and broken look-ahead fields
  task automatic send_paragraph(input int unsigned len);
    logic [3:0] cls_q[$];
    logic [5:0] lvl_q[$];
    logic [5:0] lv;
    int unsigned r;
    char_t c;
    lv = cur_base;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (r < 6) lv = 6'($urandom_range(0, 63));
      else if (r < 14) lv = lv + 6'd1;
      else if (r < 20) lv = lv - 6'd1;
      lvl_q.push_back(lv);
      if ($urandom_range(0, 99) < 6) cls_q.push_back(4'($urandom_range(0, 15)));
      else cls_q.push_back(CLASS_POOL[$urandom_range(0, 19)]);
    end
    for (int i = 0; i < len; i++) begin
      c.cls  = cls_q[i];
      c.lvl  = lvl_q[i];
      c.last = (i == len - 1);
      if (c.last || $urandom_range(0, 99) < 6) begin
        c.ncls = 4'($urandom_range(0, 15));
        c.nlvl = 6'($urandom_range(0, 63));
      end else begin
        c.ncls = cls_q[i + 1];
        c.nlvl = lvl_q[i + 1];
      end
      send_char(c);
    end
  endtask

  // Paragraphs until about target characters went in; most are short, a few
  // long enough to build real runs; some stretches run with no idling at all
  task automatic random_phase(input int unsigned target);
    int unsigned sent;
    int unsigned r;
    int unsigned len;
    sent = 0;
    while (sent < target) begin
      steady = ($urandom_range(0, 9) < 2);
      r = $urandom_range(0, 99);
      if (r < 80) len = $urandom_range(1, 10);
      else if (r < 96) len = $urandom_range(11, 40);
      else len = $urandom_range(60, 150);
      send_paragraph(len);
      sent += len;
    end
    steady = 1'b0;
  endtask

  initial begin : stimulus
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_data         <= '0;
    in_if.valid      <= 1'b0;
    in_if.class_in   <= '0;
    in_if.level_in   <= '0;
    in_if.next_class <= '0;
    in_if.next_level <= '0;
    in_if.is_last    <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed paragraph at the reset base level: every class through the
    // European/Arabic number rules, a boundary neutral with no level change,
    // one ahead of a level change, an undefined class code, and a boundary
    // neutral closing the paragraph above the base level
    send_char(char_t'{BC_L,   6'd0,  BC_EN,     6'd0,  1'b0});
    send_char(char_t'{BC_EN,  6'd0,  BC_ET,     6'd0,  1'b0});
    send_char(char_t'{BC_ET,  6'd0,  BC_CS,     6'd0,  1'b0});
    send_char(char_t'{BC_CS,  6'd0,  BC_EN,     6'd0,  1'b0});
    send_char(char_t'{BC_EN,  6'd0,  BC_ES,     6'd0,  1'b0});
    send_char(char_t'{BC_ES,  6'd0,  BC_AN,     6'd0,  1'b0});
    send_char(char_t'{BC_AN,  6'd0,  BC_CS,     6'd0,  1'b0});
    send_char(char_t'{BC_CS,  6'd0,  BC_AN,     6'd0,  1'b0});
    send_char(char_t'{BC_AN,  6'd0,  BC_NSM,    6'd0,  1'b0});
    send_char(char_t'{BC_NSM, 6'd0,  BC_AL,     6'd0,  1'b0});
    send_char(char_t'{BC_AL,  6'd0,  BC_EN,     6'd0,  1'b0});
    send_char(char_t'{BC_EN,  6'd0,  BC_R,      6'd0,  1'b0});
    send_char(char_t'{BC_R,   6'd0,  BC_ON,     6'd0,  1'b0});
    send_char(char_t'{BC_ON,  6'd0,  BC_BN,     6'd0,  1'b0});
    send_char(char_t'{BC_BN,  6'd0,  BC_BN,     6'd0,  1'b0});
    send_char(char_t'{BC_BN,  6'd0,  BC_ON,     6'd63, 1'b0});
    send_char(char_t'{BAD_CLASS, 6'd63, BAD_CLASS, 6'd63, 1'b0});
    send_char(char_t'{BC_ET,  6'd63, BC_BN,     6'd63, 1'b0});
    send_char(char_t'{BC_BN,  6'd63, BC_L,      6'd63, 1'b1});
    // Boundary neutral alone at the base level, then a lone ET paragraph
    send_char(char_t'{BC_BN,  6'd0,  BC_BN,     6'd0,  1'b1});
    send_char(char_t'{BC_ET,  6'd63, BAD_CLASS, 6'd63, 1'b1});

    write_base(6'd63);
    random_phase(117);

    // Long terminator run with a boundary neutral inside it, closed by a
    // European number
    write_base(6'd0);
    steady = 1'b1;
    send_char(char_t'{BC_L, 6'd0, BC_ET, 6'd0, 1'b0});
    for (int i = 0; i < 40; i++) send_char(char_t'{BC_ET, 6'd0, BC_ET, 6'd0, 1'b0});
    send_char(char_t'{BC_BN, 6'd0, BC_ET, 6'd0, 1'b0});
    send_char(char_t'{BC_ET, 6'd0, BC_EN, 6'd0, 1'b0});
    send_char(char_t'{BC_EN, 6'd0, BC_L,  6'd0, 1'b1});
    steady = 1'b0;
    random_phase(117);

    write_base(6'd1);
    random_phase(117);
    write_base(6'd62);
    random_phase(117);
    write_base(6'($urandom_range(0, 63)));
    random_phase(117);
    write_base(6'($urandom_range(0, 63)));
    random_phase(117);

    // Drain, then give a stray late result time to show up
    in_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/bwtr_pkg.sv
hw/rtl/bwtr_if.sv
hw/rtl/bwtr_core.sv
hw/rtl/bwtr_outq.sv
hw/rtl/bidi_weak_type_resolver.sv
dv/tb.sv
